@@ hw/rtl/spq_pkg.sv @@
`default_nettype none

package spq_pkg;

    // Queue geometry.
    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);

    // Field widths.
    localparam int SIZE_W = 32;
    localparam int PRIO_W = 8;
    localparam int ARR_W  = 17;
    localparam int OCC_W  = 5;
    localparam int ENTRY_W = SIZE_W + PRIO_W + ARR_W;

    // Stream widths.
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 64;
    localparam int M_USER_W = 3;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // One stored entry, size in the lowest bits.
    typedef struct packed {
        logic [ARR_W-1:0]  arrival;
        logic [PRIO_W-1:0] prio;
        logic [SIZE_W-1:0] size;
    } t_entry;

    // Result beat payload, size in the lowest bits.
    typedef struct packed {
        logic [M_DATA_W-ENTRY_W-OCC_W-1:0] pad;
        logic [OCC_W-1:0]                  occupancy;
        t_entry                            entry;
    } t_out_data;

    // Result sideband, entry_valid in bit 0.
    typedef struct packed {
        t_status status;
        logic    entry_valid;
    } t_out_user;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic exec;
    } t_dp_cmd;

    // Datapath status, seen by the top-level assertions.
    typedef struct packed {
        logic full;
        logic empty;
    } t_dp_sts;

endpackage

`default_nettype wire

@@ hw/rtl/spq_datapath.sv @@
`default_nettype none

module spq_datapath (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire spq_pkg::t_dp_cmd        i_cmd,
    input  wire logic [spq_pkg::S_DATA_W-1:0] i_s_tdata,
    input  wire logic                    i_s_tuser,
    output spq_pkg::t_dp_sts             o_sts,
    output logic [spq_pkg::M_DATA_W-1:0] o_m_tdata,
    output logic [spq_pkg::M_USER_W-1:0] o_m_tuser
);
    import spq_pkg::*;

    t_opcode          r_op;
    t_entry           r_in;
    t_entry           r_cells [QUEUE_DEPTH];
    t_entry           n_cells [QUEUE_DEPTH];
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    t_out_data        r_out_data;
    t_out_user        r_out_user;
    t_out_data        n_out_data;
    t_out_user        n_out_user;
    logic [QUEUE_DEPTH-1:0] w_keep;
    logic             w_full;
    logic             w_empty;
    logic             w_cell_we;

    // Capture the accepted beat.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= t_opcode'(i_s_tuser);
            r_in <= i_s_tdata[ENTRY_W-1:0];
        end
    end

    assign w_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_empty = (r_count == '0);
    assign o_sts.full  = w_full;
    assign o_sts.empty = w_empty;

    // Each cell compares its priority with the new entry at once. Occupied
    // cells are sorted, so the cells that keep their value form a prefix.
    for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
        assign w_keep[gi] = (CNT_W'(gi) < r_count) && (r_cells[gi].prio >= r_in.prio);

        if (gi == 0) begin : g_head
            always_comb begin
                if (r_op == OP_INSERT) begin
                    n_cells[gi] = w_keep[gi] ? r_cells[gi] : r_in;
                end else begin
                    n_cells[gi] = r_cells[gi + 1];
                end
            end
        end else if (gi == QUEUE_DEPTH - 1) begin : g_tail
            always_comb begin
                if (r_op == OP_INSERT) begin
                    if (w_keep[gi]) begin
                        n_cells[gi] = r_cells[gi];
                    end else if (w_keep[gi - 1]) begin
                        n_cells[gi] = r_in;
                    end else begin
                        n_cells[gi] = r_cells[gi - 1];
                    end
                end else begin
                    n_cells[gi] = r_cells[gi];
                end
            end
        end else begin : g_mid
            always_comb begin
                if (r_op == OP_INSERT) begin
                    if (w_keep[gi]) begin
                        n_cells[gi] = r_cells[gi];
                    end else if (w_keep[gi - 1]) begin
                        n_cells[gi] = r_in;
                    end else begin
                        n_cells[gi] = r_cells[gi - 1];
                    end
                end else begin
                    n_cells[gi] = r_cells[gi + 1];
                end
            end
        end
    end

    assign w_cell_we = i_cmd.exec &&
                       (((r_op == OP_INSERT) && !w_full) || ((r_op == OP_REMOVE) && !w_empty));

    // Cell chain update; contents need no reset.
    always_ff @(posedge i_clk) begin
        if (w_cell_we) begin
            r_cells <= n_cells;
        end
    end

    // Occupancy and result formation.
    always_comb begin
        n_count    = r_count;
        n_out_data = '0;
        n_out_user = '0;
        n_out_user.status = ST_OK;
        if (r_op == OP_INSERT) begin
            if (w_full) begin
                n_out_user.status = ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            if (w_empty) begin
                n_out_user.status = ST_EMPTY;
            end else begin
                n_count = r_count - CNT_W'(1);
                n_out_user.entry_valid = 1'b1;
                n_out_data.entry = r_cells[0];
            end
        end
        n_out_data.occupancy = OCC_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_data <= n_out_data;
            r_out_user <= n_out_user;
        end
    end

    assign o_m_tdata = r_out_data;
    assign o_m_tuser = r_out_user;

endmodule

`default_nettype wire

@@ hw/rtl/spq_ctrl.sv @@
`default_nettype none

module spq_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    output spq_pkg::t_dp_cmd   o_cmd
);
    import spq_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   w_out_free;

    // The output register can take a new result when empty or draining.
    assign w_out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs. Ready stays low while reset is asserted so no beat is taken then.
    always_comb begin
        o_s_tready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = i_rst_n;
                o_cmd.load = i_s_tvalid && i_rst_n;
            end
            S_EXEC: begin
                o_cmd.exec = w_out_free;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    // Result beat valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_valid;

endmodule

`default_nettype wire

@@ hw/rtl/sorted_priority_queue_unit.sv @@
`default_nettype none

// Channel   Dir  Signals                    Contents
// s         in   i_s_tvalid/o_s_tready      tdata: job_size, priority_level, arrival_second
//                                           tuser: opcode
// m         out  o_m_tvalid/i_m_tready      tdata: out_size, out_priority, out_arrival,
//                                                  occupancy
//                                           tuser: entry_valid, status_code
//
// Each item is handled in a capture step that takes the beat, then an update
// step that updates the sorted cell chain and loads the output register.
// A new beat is accepted while the previous result waits in the output register.
// The update cycle holds while the output register still has an untaken result.
// Reset is synchronous, active low; it empties the queue and the output stage.

module sorted_priority_queue_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    // [31:0] job_size, [39:32] priority_level, [56:40] arrival_second
    input  wire logic [spq_pkg::S_DATA_W-1:0]    i_s_tdata,
    // [0] opcode
    input  wire logic                            i_s_tuser,
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    // [31:0] out_size, [39:32] out_priority, [56:40] out_arrival, [61:57] occupancy
    output logic [spq_pkg::M_DATA_W-1:0]         o_m_tdata,
    // [0] entry_valid, [2:1] status_code
    output logic [spq_pkg::M_USER_W-1:0]         o_m_tuser
);
    import spq_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    spq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (w_cmd)
    );

    spq_datapath u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_sts     (w_sts),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser)
    );

    // An update always leaves a result beat in the output register.
    a_exec_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.exec |=> o_m_tvalid)
        else $error("update did not present a result beat");

    // Capture and update never overlap.
    a_no_load_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.exec && w_cmd.load))
        else $error("capture and update in the same cycle");

    // The queue cannot be full and empty at once.
    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_sts.full && w_sts.empty))
        else $error("queue reports full and empty");

    // A returned entry always carries an ok status.
    a_entry_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tuser[2:1] == ST_OK))
        else $error("returned entry with error status");

    // An update on an empty queue never returns an entry.
    a_empty_no_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.exec && w_sts.empty) |=> !o_m_tuser[0])
        else $error("entry returned from empty queue");

endmodule

`default_nettype wire
